// File: rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the lexical token scanner
// scan modes, token kinds, keyword table and the record type of the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lts_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int KEYWORD_MAX_DEF = 5;
    localparam int FIELD_W         = 16;
    localparam int KIND_W          = 6;
    localparam int KW_COUNT        = 11;
    localparam int KW_TEXT_MAX     = 8;
    localparam int QUEUE_DEPTH     = 8;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int MAX_RECORDS     = 3;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'd0,
        MODE_COMMENT  = 4'd1,
        MODE_STRING   = 4'd2,
        MODE_NUM      = 4'd3,
        MODE_NUMDOT   = 4'd4,
        MODE_FRAC     = 4'd5,
        MODE_IDENT    = 4'd6,
        MODE_MINUS    = 4'd7,
        MODE_ARROW    = 4'd8,
        MODE_LESS     = 4'd9,
        MODE_GREATER  = 4'd10,
        MODE_EQUAL    = 4'd11
    } scan_mode_t;

    typedef enum logic [KIND_W-1:0] {
        TK_EOF        = 6'd0,
        TK_NEWLINE    = 6'd1,
        TK_LPAREN     = 6'd2,
        TK_RPAREN     = 6'd3,
        TK_LBRACE     = 6'd4,
        TK_RBRACE     = 6'd5,
        TK_COMMA      = 6'd6,
        TK_DOT        = 6'd7,
        TK_MINUS      = 6'd8,
        TK_RARROW     = 6'd9,
        TK_DRARROW    = 6'd10,
        TK_PLUS       = 6'd11,
        TK_SLASH      = 6'd12,
        TK_STAR       = 6'd13,
        TK_EQ         = 6'd14,
        TK_EQEQ       = 6'd15,
        TK_LT         = 6'd16,
        TK_LE         = 6'd17,
        TK_LARROW     = 6'd18,
        TK_GT         = 6'd19,
        TK_GE         = 6'd20,
        TK_NUMBER     = 6'd21,
        TK_STRING     = 6'd22,
        TK_IDENT      = 6'd23,
        TK_KW_FIRST   = 6'd24,
        TK_UNEXPECTED = 6'd35,
        TK_UNTERM     = 6'd36
    } token_kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] line;
        logic               last;
    } token_rec_t;

    typedef logic [KW_TEXT_MAX-1:0][7:0] kw_text_t;

    // keyword spelling, first byte in entry 0, zero padded
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        {8'h00, 8'h00, 8'h00, 8'h00, "e", "u", "r", "t"},
        {8'h00, 8'h00, 8'h00, "e", "s", "l", "a", "f"},
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "r", "o"},
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "d", "n", "a"},
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
        {8'h00, 8'h00, 8'h00, 8'h00, "e", "s", "l", "e"},
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "r", "o", "f"},
        {8'h00, 8'h00, 8'h00, "e", "l", "i", "h", "w"},
        {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "l", "i", "n"},
        {8'h00, 8'h00, 8'h00, "s", "s", "a", "l", "c"},
        {8'h00, 8'h00, 8'h00, 8'h00, "f", "l", "e", "s"}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd2, 4'd3, 4'd2, 4'd4, 4'd3, 4'd5, 4'd3, 4'd5, 4'd4
    };

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LESS  = 8'h3C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_GREAT = 8'h3E;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

endpackage

// File: rtl/lexical_token_scanner.sv
// ----------------------------------------------------------------------------
// lexical_token_scanner: byte-serial tokenizer emitting token records
// records enter the queue when their byte is taken; the head drives the output
// throughput: one byte per cycle while the 8-entry record queue has room for 3
// records go out one per cycle unless out_stall; multi-record bytes slow input
// reset (async, rst_n low): queue empty, mode idle, offset 0, line 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lexical_token_scanner #(
    parameter int OFFSET_BITS = lts_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_MAX = lts_pkg::KEYWORD_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    // record channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic [15:0] line_number,
    output logic        last_of_run
);

    // offsets carry one spare bit so that position + 1 never wraps
    localparam int OW1    = OFFSET_BITS + 1;
    // ident length counts up to KEYWORD_MAX + 1 and then holds
    localparam int IDLEN_W = $clog2(KEYWORD_MAX + 2);
    localparam int CNT_W   = lts_pkg::QUEUE_PTR_W + 1;
    localparam int PTR_W   = lts_pkg::QUEUE_PTR_W;

    // ------------------------------------------------------------------
    // scanner state
    // ------------------------------------------------------------------
    lts_pkg::scan_mode_t                mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]             pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]             start_reg, start_next;
    logic [lts_pkg::FIELD_W-1:0]        line_reg, line_next;
    logic [KEYWORD_MAX-1:0][7:0]        kwbuf_reg, kwbuf_next;
    logic [IDLEN_W-1:0]                 idlen_reg, idlen_next;

    // record queue
    lts_pkg::token_rec_t                queue_mem [lts_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]                   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]                   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                   count_reg, count_next;

    logic in_accept;
    logic out_accept;

    // saturate an offset or length to the 16-bit record field
    function automatic logic [lts_pkg::FIELD_W-1:0] sat16(input logic [OW1-1:0] v);
        logic [lts_pkg::FIELD_W-1:0] r;
        if (OW1 > lts_pkg::FIELD_W && v > OW1'({lts_pkg::FIELD_W{1'b1}}))
            r = '1;
        else
            r = lts_pkg::FIELD_W'(v);
        return r;
    endfunction

    function automatic lts_pkg::token_rec_t mk_rec(
        input logic [lts_pkg::KIND_W-1:0]  kind,
        input logic [OW1-1:0]              start,
        input logic [OW1-1:0]              len,
        input logic [lts_pkg::FIELD_W-1:0] line
    );
        lts_pkg::token_rec_t r;
        r.kind   = kind;
        r.start  = sat16(start);
        r.length = sat16(len);
        r.line   = line;
        r.last   = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // character classes and the length candidates for this byte
    // ------------------------------------------------------------------
    logic                 c_digit, c_alpha;
    logic [OW1-1:0]       p_ext, ts_ext, p_plus1, p_minus1;
    logic [OW1-1:0]       len_here, len_incl, len_before_dot;
    logic [lts_pkg::FIELD_W-1:0] line_inc;
    logic [lts_pkg::KIND_W-1:0]  ident_kind;

    always_comb
    begin
        c_digit = (char_code >= "0") && (char_code <= "9");
        c_alpha = ((char_code >= "a") && (char_code <= "z")) ||
                  ((char_code >= "A") && (char_code <= "Z")) || (char_code == "_");

        p_ext    = {1'b0, pos_reg};
        ts_ext   = {1'b0, start_reg};
        p_plus1  = p_ext + OW1'(1);
        p_minus1 = (p_ext != '0) ? p_ext - OW1'(1) : '0;

        // token ending before this byte, and token including this byte
        len_here       = (p_ext > ts_ext)    ? p_ext - ts_ext    : '0;
        len_incl       = (p_plus1 > ts_ext)  ? p_plus1 - ts_ext  : '0;
        // number left behind by a dot that turned out not to be fractional
        len_before_dot = (p_minus1 > ts_ext) ? p_minus1 - ts_ext : '0;

        line_inc = (line_reg != '1) ? line_reg + lts_pkg::FIELD_W'(1) : line_reg;
    end

    // keyword match: eleven independent compares against the buffer
    always_comb
    begin
        logic hit;
        ident_kind = lts_pkg::TK_IDENT;
        for (int k = lts_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            hit = (IDLEN_W'(lts_pkg::KW_LEN[k]) == idlen_reg) &&
                  (int'(lts_pkg::KW_LEN[k]) <= KEYWORD_MAX);
            for (int i = 0; i < KEYWORD_MAX; i++)
            begin
                if (i < int'(lts_pkg::KW_LEN[k]) && i < lts_pkg::KW_TEXT_MAX)
                    hit = hit && (kwbuf_reg[i] == lts_pkg::KW_TEXT[k][i]);
            end
            if (hit)
                ident_kind = lts_pkg::TK_KW_FIRST + lts_pkg::KIND_W'(k);
        end
    end

    // ------------------------------------------------------------------
    // one pass per byte: first close any pending token, then start fresh
    // ------------------------------------------------------------------
    lts_pkg::token_rec_t rec_a0, rec_a1, rec_f;
    logic                a0_v, a1_v, f_v, fresh;
    logic                end_of_source;

    always_comb
    begin
        mode_next     = mode_reg;
        start_next    = start_reg;
        line_next     = line_reg;
        kwbuf_next    = kwbuf_reg;
        idlen_next    = idlen_reg;
        pos_next      = (pos_reg != '1) ? pos_reg + OFFSET_BITS'(1) : pos_reg;
        rec_a0        = '0;
        rec_a1        = '0;
        rec_f         = '0;
        a0_v          = 1'b0;
        a1_v          = 1'b0;
        f_v           = 1'b0;
        fresh         = 1'b0;
        end_of_source = 1'b0;

        // pending token decided by this byte
        unique case (mode_reg)
            lts_pkg::MODE_COMMENT:
            begin
                if (char_code == lts_pkg::CH_NL || char_code == lts_pkg::CH_END)
                begin
                    mode_next = lts_pkg::MODE_IDLE;
                    fresh     = 1'b1;
                end
            end
            lts_pkg::MODE_STRING:
            begin
                if (char_code == lts_pkg::CH_END)
                begin
                    rec_a0    = mk_rec(lts_pkg::TK_UNTERM, ts_ext, len_here, line_reg);
                    a0_v      = 1'b1;
                    mode_next = lts_pkg::MODE_IDLE;
                    fresh     = 1'b1;
                end
                else if (char_code == lts_pkg::CH_QUOTE)
                begin
                    rec_a0    = mk_rec(lts_pkg::TK_STRING, ts_ext, len_incl, line_reg);
                    a0_v      = 1'b1;
                    mode_next = lts_pkg::MODE_IDLE;
                end
                else if (char_code == lts_pkg::CH_NL)
                begin
                    line_next = line_inc;
                end
            end
            lts_pkg::MODE_NUM, lts_pkg::MODE_FRAC:
            begin
                if (char_code == lts_pkg::CH_DOT && mode_reg == lts_pkg::MODE_NUM)
                begin
                    mode_next = lts_pkg::MODE_NUMDOT;
                end
                else if (!c_digit)
                begin
                    rec_a0    = mk_rec(lts_pkg::TK_NUMBER, ts_ext, len_here, line_reg);
                    a0_v      = 1'b1;
                    mode_next = lts_pkg::MODE_IDLE;
                    fresh     = 1'b1;
                end
            end
            lts_pkg::MODE_NUMDOT:
            begin
                if (c_digit)
                begin
                    mode_next = lts_pkg::MODE_FRAC;
                end
                else
                begin
                    // number without the dot, then the dot on its own
                    rec_a0 = mk_rec(lts_pkg::TK_NUMBER, ts_ext, len_before_dot, line_reg);
                    rec_a1 = mk_rec(lts_pkg::TK_DOT, p_minus1, OW1'(1), line_reg);
                    a0_v      = 1'b1;
                    a1_v      = 1'b1;
                    mode_next = lts_pkg::MODE_IDLE;
                    fresh     = 1'b1;
                end
            end
            lts_pkg::MODE_IDENT:
            begin
                if (c_alpha || c_digit)
                begin
                    for (int i = 0; i < KEYWORD_MAX; i++)
                    begin
                        if (idlen_reg == IDLEN_W'(i))
                            kwbuf_next[i] = char_code;
                    end
                    if (idlen_reg <= IDLEN_W'(KEYWORD_MAX))
                        idlen_next = idlen_reg + IDLEN_W'(1);
                end
                else
                begin
                    rec_a0    = mk_rec(ident_kind, ts_ext, len_here, line_reg);
                    a0_v      = 1'b1;
                    mode_next = lts_pkg::MODE_IDLE;
                    fresh     = 1'b1;
                end
            end
            lts_pkg::MODE_MINUS:
            begin
                if (char_code == lts_pkg::CH_GREAT)
                begin
                    mode_next = lts_pkg::MODE_ARROW;
                end
                else
                begin
                    rec_a0    = mk_rec(lts_pkg::TK_MINUS, ts_ext, len_here, line_reg);
                    a0_v      = 1'b1;
                    mode_next = lts_pkg::MODE_IDLE;
                    fresh     = 1'b1;
                end
            end
            lts_pkg::MODE_ARROW:
            begin
                mode_next = lts_pkg::MODE_IDLE;
                a0_v      = 1'b1;
                if (char_code == lts_pkg::CH_GREAT)
                    rec_a0 = mk_rec(lts_pkg::TK_DRARROW, ts_ext, len_incl, line_reg);
                else
                begin
                    rec_a0 = mk_rec(lts_pkg::TK_RARROW, ts_ext, len_here, line_reg);
                    fresh  = 1'b1;
                end
            end
            lts_pkg::MODE_LESS:
            begin
                mode_next = lts_pkg::MODE_IDLE;
                a0_v      = 1'b1;
                if (char_code == lts_pkg::CH_MINUS)
                    rec_a0 = mk_rec(lts_pkg::TK_LARROW, ts_ext, len_incl, line_reg);
                else if (char_code == lts_pkg::CH_EQUAL)
                    rec_a0 = mk_rec(lts_pkg::TK_LE, ts_ext, len_incl, line_reg);
                else
                begin
                    rec_a0 = mk_rec(lts_pkg::TK_LT, ts_ext, len_here, line_reg);
                    fresh  = 1'b1;
                end
            end
            lts_pkg::MODE_GREATER:
            begin
                mode_next = lts_pkg::MODE_IDLE;
                a0_v      = 1'b1;
                if (char_code == lts_pkg::CH_EQUAL)
                    rec_a0 = mk_rec(lts_pkg::TK_GE, ts_ext, len_incl, line_reg);
                else
                begin
                    rec_a0 = mk_rec(lts_pkg::TK_GT, ts_ext, len_here, line_reg);
                    fresh  = 1'b1;
                end
            end
            lts_pkg::MODE_EQUAL:
            begin
                mode_next = lts_pkg::MODE_IDLE;
                a0_v      = 1'b1;
                if (char_code == lts_pkg::CH_EQUAL)
                    rec_a0 = mk_rec(lts_pkg::TK_EQEQ, ts_ext, len_incl, line_reg);
                else
                begin
                    rec_a0 = mk_rec(lts_pkg::TK_EQ, ts_ext, len_here, line_reg);
                    fresh  = 1'b1;
                end
            end
            default:
            begin
                mode_next = lts_pkg::MODE_IDLE;
                fresh     = 1'b1;
            end
        endcase

        // byte not absorbed by a pending token: it begins something new
        if (fresh)
        begin
            start_next = pos_reg;
            unique case (char_code)
                lts_pkg::CH_END:
                begin
                    // end of source: eof record, then back to the start of a file
                    rec_f         = mk_rec(lts_pkg::TK_EOF, p_ext, '0, line_reg);
                    f_v           = 1'b1;
                    end_of_source = 1'b1;
                    pos_next      = '0;
                    start_next    = '0;
                    line_next     = lts_pkg::FIELD_W'(1);
                    mode_next     = lts_pkg::MODE_IDLE;
                end
                lts_pkg::CH_SPACE, lts_pkg::CH_CR, lts_pkg::CH_TAB:
                begin
                end
                lts_pkg::CH_NL:
                begin
                    // newline record carries the line it opens
                    line_next = line_inc;
                    rec_f     = mk_rec(lts_pkg::TK_NEWLINE, p_ext, OW1'(1), line_inc);
                    f_v       = 1'b1;
                end
                lts_pkg::CH_HASH:  mode_next = lts_pkg::MODE_COMMENT;
                lts_pkg::CH_MINUS: mode_next = lts_pkg::MODE_MINUS;
                lts_pkg::CH_LESS:  mode_next = lts_pkg::MODE_LESS;
                lts_pkg::CH_GREAT: mode_next = lts_pkg::MODE_GREATER;
                lts_pkg::CH_EQUAL: mode_next = lts_pkg::MODE_EQUAL;
                lts_pkg::CH_QUOTE: mode_next = lts_pkg::MODE_STRING;
                lts_pkg::CH_LPAR, lts_pkg::CH_RPAR, lts_pkg::CH_LBRC, lts_pkg::CH_RBRC,
                lts_pkg::CH_COMMA, lts_pkg::CH_DOT, lts_pkg::CH_PLUS, lts_pkg::CH_SLASH,
                lts_pkg::CH_STAR:
                begin
                    f_v = 1'b1;
                    unique case (char_code)
                        lts_pkg::CH_LPAR:  rec_f.kind = lts_pkg::TK_LPAREN;
                        lts_pkg::CH_RPAR:  rec_f.kind = lts_pkg::TK_RPAREN;
                        lts_pkg::CH_LBRC:  rec_f.kind = lts_pkg::TK_LBRACE;
                        lts_pkg::CH_RBRC:  rec_f.kind = lts_pkg::TK_RBRACE;
                        lts_pkg::CH_COMMA: rec_f.kind = lts_pkg::TK_COMMA;
                        lts_pkg::CH_DOT:   rec_f.kind = lts_pkg::TK_DOT;
                        lts_pkg::CH_PLUS:  rec_f.kind = lts_pkg::TK_PLUS;
                        lts_pkg::CH_SLASH: rec_f.kind = lts_pkg::TK_SLASH;
                        default:           rec_f.kind = lts_pkg::TK_STAR;
                    endcase
                    rec_f.start  = sat16(p_ext);
                    rec_f.length = lts_pkg::FIELD_W'(1);
                    rec_f.line   = line_reg;
                end
                default:
                begin
                    if (c_digit)
                    begin
                        mode_next = lts_pkg::MODE_NUM;
                    end
                    else if (c_alpha)
                    begin
                        kwbuf_next    = '0;
                        kwbuf_next[0] = char_code;
                        idlen_next    = IDLEN_W'(1);
                        mode_next     = lts_pkg::MODE_IDENT;
                    end
                    else
                    begin
                        rec_f = mk_rec(lts_pkg::TK_UNEXPECTED, p_ext, OW1'(1), line_reg);
                        f_v   = 1'b1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pack the up-to-three records of this byte in order; mark the last
    // ------------------------------------------------------------------
    lts_pkg::token_rec_t push_rec [lts_pkg::MAX_RECORDS];
    logic [1:0]          push_n;

    always_comb
    begin
        push_n      = 2'(a0_v) + 2'(a1_v) + 2'(f_v);
        push_rec[0] = a0_v ? rec_a0 : rec_f;
        push_rec[1] = a1_v ? rec_a1 : rec_f;
        push_rec[2] = rec_f;
        for (int j = 0; j < lts_pkg::MAX_RECORDS; j++)
            push_rec[j].last = (push_n == 2'(j + 1));
    end

    // ------------------------------------------------------------------
    // handshakes: input stalls unless a worst-case byte still fits
    // ------------------------------------------------------------------
    assign in_stall   = (count_reg > CNT_W'(lts_pkg::QUEUE_DEPTH - lts_pkg::MAX_RECORDS));
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (count_reg != '0);
    assign out_accept = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_accept)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
            count_next  = count_next + CNT_W'(push_n);
        end
        if (out_accept)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            count_next  = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lts_pkg::MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            line_reg   <= lts_pkg::FIELD_W'(1);
            kwbuf_reg  <= '0;
            idlen_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                line_reg  <= line_next;
                kwbuf_reg <= kwbuf_next;
                idlen_reg <= idlen_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record queue storage, payload only
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int j = 0; j < lts_pkg::MAX_RECORDS; j++)
            begin
                if (2'(j) < push_n)
                    queue_mem[wr_ptr_reg + PTR_W'(j)] <= push_rec[j];
            end
        end
    end

    // head of the queue drives the record word
    assign token_kind   = queue_mem[rd_ptr_reg].kind;
    assign start_offset = queue_mem[rd_ptr_reg].start;
    assign token_length = queue_mem[rd_ptr_reg].length;
    assign line_number  = queue_mem[rd_ptr_reg].line;
    assign last_of_run  = queue_mem[rd_ptr_reg].last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(lts_pkg::QUEUE_DEPTH))
        else $error("record queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (count_reg + CNT_W'(push_n) <= CNT_W'(lts_pkg::QUEUE_DEPTH)))
        else $error("accepted byte overflows record queue");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_of_source) |=>
            (pos_reg == '0 && line_reg == lts_pkg::FIELD_W'(1) &&
             mode_reg == lts_pkg::MODE_IDLE))
        else $error("end of source did not restart position and line");

    a_ident_len: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == lts_pkg::MODE_IDENT) |-> (idlen_reg != '0))
        else $error("identifier mode with empty length");

endmodule

// File: dv/tb_lexical_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lexical_token_scanner: self-checking bench of the byte-serial tokenizer
// source bytes go in through the valid/stall byte channel while a scanner model
// kept in the bench predicts every token record; each record that leaves is
// compared field by field with the oldest prediction. covers directed corner
// cases and random well-formed source mixed with noise
// ----------------------------------------------------------------------------

module tb_lexical_token_scanner;

    localparam int RANDOM_BYTES    = 440;
    localparam int KW_BYTES        = lts_pkg::KEYWORD_MAX_DEF;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic [15:0] FIELD_TOP = 16'hFFFF;

    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // clock, reset and the two channels, all known from time zero
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code    = 8'h00;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;

    // scanner model state
    lts_pkg::scan_mode_t lex_mode     = lts_pkg::MODE_IDLE;
    logic [15:0]         lex_pos      = 16'd0;
    logic [15:0]         lex_start    = 16'd0;
    logic [15:0]         lex_line     = 16'd1;
    logic [7:0]          lex_word [KW_BYTES];
    int                  lex_word_len = 0;

    lts_pkg::token_rec_t step_tokens [$];   // records caused by the byte being scanned
    lts_pkg::token_rec_t tokens_due [$];    // predicted records not yet seen at the output
    logic [7:0]          source_bytes [$];  // source text waiting to be sent

    int mismatch_count = 0;
    int cycle_count    = 0;

    // sender bursts and receiver stall pattern
    int gap_max    = 0;
    int burst_left = 0;
    int stall_pct  = 0;
    int stall_run  = 0;
    bit stall_hold = 1'b0;

    always #5 clk = ~clk;

    lexical_token_scanner i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_number  (line_number),
        .last_of_run  (last_of_run)
    );

    // ------------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------------

    function automatic string keyword_spelling(input int k);
        case (k)
            0:       return "true";
            1:       return "false";
            2:       return "or";
            3:       return "and";
            4:       return "if";
            5:       return "else";
            6:       return "for";
            7:       return "while";
            8:       return "nil";
            9:       return "class";
            10:      return "self";
            default: return "";
        endcase
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
    endfunction

    function automatic bit letter_char(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            || c == CH_UNDERSCORE;
    endfunction

    // record spanning [first, stop), offsets and length clipped to 16 bits
    function automatic void add_token(input logic [5:0] kind, input int first, input int stop);
        lts_pkg::token_rec_t rec;
        int                  len;
        len        = (stop > first) ? stop - first : 0;
        rec.kind   = kind;
        rec.start  = (first > 65535) ? FIELD_TOP : 16'(first);
        rec.length = (len > 65535) ? FIELD_TOP : 16'(len);
        rec.line   = lex_line;
        rec.last   = 1'b0;
        step_tokens = {step_tokens, rec};
    endfunction

    // keyword lookup on the buffered prefix and the saturating length
    function automatic logic [5:0] ident_kind();
        string spelling;
        bit    hit;
        for (int k = 0; k < lts_pkg::KW_COUNT; k++)
        begin
            spelling = keyword_spelling(k);
            if (spelling.len() == lex_word_len && spelling.len() <= KW_BYTES)
            begin
                hit = 1'b1;
                for (int i = 0; i < spelling.len(); i++)
                    if (lex_word[i] != spelling[i]) hit = 1'b0;
                if (hit) return 6'(lts_pkg::TK_KW_FIRST + k);
            end
        end
        return lts_pkg::TK_IDENT;
    endfunction

    // scan one accepted byte and queue the records it causes
    function automatic void lex_byte(input logic [7:0] c);
        int                  p;
        int                  dot_at;
        bit                  restart;
        lts_pkg::token_rec_t rec;
        p       = lex_pos;
        dot_at  = (p > 0) ? p - 1 : 0;
        restart = 1'b0;
        step_tokens.delete();

        // first settle whatever token is pending from earlier bytes
        case (lex_mode)
            lts_pkg::MODE_COMMENT:
                if (c == lts_pkg::CH_NL || c == lts_pkg::CH_END) restart = 1'b1;
            lts_pkg::MODE_STRING:
                if (c == lts_pkg::CH_END)
                begin
                    add_token(lts_pkg::TK_UNTERM, lex_start, p);
                    restart = 1'b1;
                end
                else if (c == lts_pkg::CH_QUOTE)
                begin
                    add_token(lts_pkg::TK_STRING, lex_start, p + 1);
                    lex_mode = lts_pkg::MODE_IDLE;
                end
                else if (c == lts_pkg::CH_NL && lex_line != FIELD_TOP)
                begin
                    lex_line++;
                end
            lts_pkg::MODE_NUM:
                if (c == lts_pkg::CH_DOT)
                begin
                    lex_mode = lts_pkg::MODE_NUMDOT;
                end
                else if (!digit_char(c))
                begin
                    add_token(lts_pkg::TK_NUMBER, lex_start, p);
                    restart = 1'b1;
                end
            lts_pkg::MODE_NUMDOT:
                if (digit_char(c))
                begin
                    lex_mode = lts_pkg::MODE_FRAC;
                end
                else
                begin
                    // the dot was not a fraction: number, then a lone dot
                    add_token(lts_pkg::TK_NUMBER, lex_start, dot_at);
                    add_token(lts_pkg::TK_DOT, dot_at, dot_at + 1);
                    restart = 1'b1;
                end
            lts_pkg::MODE_FRAC:
                if (!digit_char(c))
                begin
                    add_token(lts_pkg::TK_NUMBER, lex_start, p);
                    restart = 1'b1;
                end
            lts_pkg::MODE_IDENT:
                if (letter_char(c) || digit_char(c))
                begin
                    if (lex_word_len < KW_BYTES) lex_word[lex_word_len] = c;
                    if (lex_word_len <= KW_BYTES) lex_word_len++;
                end
                else
                begin
                    add_token(ident_kind(), lex_start, p);
                    restart = 1'b1;
                end
            lts_pkg::MODE_MINUS:
                if (c == lts_pkg::CH_GREAT)
                begin
                    lex_mode = lts_pkg::MODE_ARROW;
                end
                else
                begin
                    add_token(lts_pkg::TK_MINUS, lex_start, p);
                    restart = 1'b1;
                end
            lts_pkg::MODE_ARROW:
                if (c == lts_pkg::CH_GREAT)
                begin
                    add_token(lts_pkg::TK_DRARROW, lex_start, p + 1);
                    lex_mode = lts_pkg::MODE_IDLE;
                end
                else
                begin
                    add_token(lts_pkg::TK_RARROW, lex_start, p);
                    restart = 1'b1;
                end
            lts_pkg::MODE_LESS:
                if (c == lts_pkg::CH_MINUS)
                begin
                    add_token(lts_pkg::TK_LARROW, lex_start, p + 1);
                    lex_mode = lts_pkg::MODE_IDLE;
                end
                else if (c == lts_pkg::CH_EQUAL)
                begin
                    add_token(lts_pkg::TK_LE, lex_start, p + 1);
                    lex_mode = lts_pkg::MODE_IDLE;
                end
                else
                begin
                    add_token(lts_pkg::TK_LT, lex_start, p);
                    restart = 1'b1;
                end
            lts_pkg::MODE_GREATER:
                if (c == lts_pkg::CH_EQUAL)
                begin
                    add_token(lts_pkg::TK_GE, lex_start, p + 1);
                    lex_mode = lts_pkg::MODE_IDLE;
                end
                else
                begin
                    add_token(lts_pkg::TK_GT, lex_start, p);
                    restart = 1'b1;
                end
            lts_pkg::MODE_EQUAL:
                if (c == lts_pkg::CH_EQUAL)
                begin
                    add_token(lts_pkg::TK_EQEQ, lex_start, p + 1);
                    lex_mode = lts_pkg::MODE_IDLE;
                end
                else
                begin
                    add_token(lts_pkg::TK_EQ, lex_start, p);
                    restart = 1'b1;
                end
            default:
                restart = 1'b1;
        endcase

        // then the byte itself opens whatever comes next
        if (restart)
        begin
            lex_mode  = lts_pkg::MODE_IDLE;
            lex_start = 16'(p);
            case (c)
                lts_pkg::CH_END:
                begin
                    add_token(lts_pkg::TK_EOF, p, p);
                    lex_pos   = 16'd0;
                    lex_start = 16'd0;
                    lex_line  = 16'd1;
                end
                lts_pkg::CH_SPACE, lts_pkg::CH_CR, lts_pkg::CH_TAB:
                begin
                end
                lts_pkg::CH_NL:
                begin
                    if (lex_line != FIELD_TOP) lex_line++;
                    add_token(lts_pkg::TK_NEWLINE, p, p + 1);
                end
                lts_pkg::CH_HASH:  lex_mode = lts_pkg::MODE_COMMENT;
                lts_pkg::CH_LPAR:  add_token(lts_pkg::TK_LPAREN, p, p + 1);
                lts_pkg::CH_RPAR:  add_token(lts_pkg::TK_RPAREN, p, p + 1);
                lts_pkg::CH_LBRC:  add_token(lts_pkg::TK_LBRACE, p, p + 1);
                lts_pkg::CH_RBRC:  add_token(lts_pkg::TK_RBRACE, p, p + 1);
                lts_pkg::CH_COMMA: add_token(lts_pkg::TK_COMMA, p, p + 1);
                lts_pkg::CH_DOT:   add_token(lts_pkg::TK_DOT, p, p + 1);
                lts_pkg::CH_PLUS:  add_token(lts_pkg::TK_PLUS, p, p + 1);
                lts_pkg::CH_SLASH: add_token(lts_pkg::TK_SLASH, p, p + 1);
                lts_pkg::CH_STAR:  add_token(lts_pkg::TK_STAR, p, p + 1);
                lts_pkg::CH_MINUS: lex_mode = lts_pkg::MODE_MINUS;
                lts_pkg::CH_LESS:  lex_mode = lts_pkg::MODE_LESS;
                lts_pkg::CH_GREAT: lex_mode = lts_pkg::MODE_GREATER;
                lts_pkg::CH_EQUAL: lex_mode = lts_pkg::MODE_EQUAL;
                lts_pkg::CH_QUOTE: lex_mode = lts_pkg::MODE_STRING;
                default:
                    if (digit_char(c))
                    begin
                        lex_mode = lts_pkg::MODE_NUM;
                    end
                    else if (letter_char(c))
                    begin
                        foreach (lex_word[i]) lex_word[i] = 8'h00;
                        lex_word[0]  = c;
                        lex_word_len = 1;
                        lex_mode     = lts_pkg::MODE_IDENT;
                    end
                    else
                    begin
                        add_token(lts_pkg::TK_UNEXPECTED, p, p + 1);
                    end
            endcase
        end

        // end of source already cleared the offset
        if (c != lts_pkg::CH_END && lex_pos != FIELD_TOP) lex_pos++;

        // only the final record of the byte carries last_of_run
        foreach (step_tokens[i])
        begin
            rec        = step_tokens[i];
            rec.last   = (i == step_tokens.size() - 1);
            tokens_due = {tokens_due, rec};
        end
    endfunction

    // ------------------------------------------------------------------------
    // byte channel: bursts of back-to-back words with random gaps between
    // ------------------------------------------------------------------------

    // called and returning at a falling edge
    task automatic send_byte(input logic [7:0] c);
        int gap;
        if (burst_left == 0)
        begin
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // word taken at this edge
        lex_byte(c);
        @(negedge clk);
    endtask

    task automatic send_source();
        foreach (source_bytes[i]) send_byte(source_bytes[i]);
        source_bytes.delete();
    endtask

    function automatic void queue_byte(input logic [7:0] b);
        source_bytes = {source_bytes, b};
    endfunction

    function automatic void append_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endfunction

    function automatic logic [7:0] ident_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'(CH_LOWER_A + r);
        if (r < 52) return 8'(CH_UPPER_A + r - 26);
        if (r == 52) return CH_UNDERSCORE;
        return 8'(CH_ZERO + r - 53);
    endfunction

    // one random lexeme; no separator, so neighbors run into each other and
    // exercise the lookahead states
    function automatic void append_lexeme();
        int         pick;
        int         n;
        logic [7:0] b;
        string      op;
        pick = $urandom_range(0, 99);
        if (pick < 14)
        begin
            append_text(keyword_spelling($urandom_range(0, lts_pkg::KW_COUNT - 1)));
        end
        else if (pick < 26)
        begin
            // identifiers, a third of them grown from a keyword
            if ($urandom_range(0, 2) == 0)
                append_text(keyword_spelling($urandom_range(0, lts_pkg::KW_COUNT - 1)));
            else
                queue_byte(ident_char(1'b1));
            n = $urandom_range(0, 7);
            repeat (n) queue_byte(ident_char(1'b0));
        end
        else if (pick < 40)
        begin
            // integer, fraction, or a trailing dot left for the next lexeme
            n = $urandom_range(1, 4);
            repeat (n) queue_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            case ($urandom_range(0, 2))
                1:
                begin
                    queue_byte(lts_pkg::CH_DOT);
                    n = $urandom_range(1, 3);
                    repeat (n) queue_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                2: queue_byte(lts_pkg::CH_DOT);
                default:
                begin
                end
            endcase
        end
        else if (pick < 50)
        begin
            // string with arbitrary bytes and newlines, sometimes left open
            queue_byte(lts_pkg::CH_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                b = 8'($urandom_range(1, 255));
                if (b == lts_pkg::CH_QUOTE || $urandom_range(0, 3) == 0) b = lts_pkg::CH_NL;
                queue_byte(b);
            end
            if ($urandom_range(0, 6) != 0) queue_byte(lts_pkg::CH_QUOTE);
        end
        else if (pick < 75)
        begin
            case ($urandom_range(0, 18))
                0:       op = "(";
                1:       op = ")";
                2:       op = "{";
                3:       op = "}";
                4:       op = ",";
                5:       op = ".";
                6:       op = "+";
                7:       op = "/";
                8:       op = "*";
                9:       op = "-";
                10:      op = "->";
                11:      op = "->>";
                12:      op = "<";
                13:      op = "<=";
                14:      op = "<-";
                15:      op = ">";
                16:      op = ">=";
                17:      op = "=";
                default: op = "==";
            endcase
            append_text(op);
        end
        else if (pick < 87)
        begin
            case ($urandom_range(0, 3))
                0:       queue_byte(lts_pkg::CH_SPACE);
                1:       queue_byte(lts_pkg::CH_TAB);
                2:       queue_byte(lts_pkg::CH_CR);
                default: queue_byte(lts_pkg::CH_NL);
            endcase
        end
        else if (pick < 93)
        begin
            // comment, usually closed by a newline
            queue_byte(lts_pkg::CH_HASH);
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                b = 8'($urandom_range(1, 255));
                if (b == lts_pkg::CH_NL) b = lts_pkg::CH_SPACE;
                queue_byte(b);
            end
            if ($urandom_range(0, 4) != 0) queue_byte(lts_pkg::CH_NL);
        end
        else
        begin
            // noise: any nonzero byte
            queue_byte(8'($urandom_range(1, 255)));
        end
    endfunction

    // ------------------------------------------------------------------------
    // record channel: receiver stalls in runs of random length and density
    // ------------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_run  = $urandom_range(1, 16);
            stall_hold = ($urandom_range(0, 99) < stall_pct);
        end
        stall_run--;
        out_stall <= stall_hold;
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // every record word leaving the block is matched against the oldest prediction
    always @(posedge clk)
    begin : record_check
        lts_pkg::token_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tokens_due.size() == 0)
            begin
                $display("%0t: record with nothing expected: kind %0d start %0d len %0d line %0d",
                         $time, token_kind, start_offset, token_length, line_number);
                mismatch_count++;
            end
            else
            begin
                want = tokens_due.pop_front();
                check_field("token_kind", 16'(want.kind), 16'(token_kind));
                check_field("start_offset", want.start, start_offset);
                check_field("token_length", want.length, token_length);
                check_field("line_number", want.line, line_number);
                check_field("last_of_run", 16'(want.last), 16'(last_of_run));
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_lexical_token_scanner: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // end of source straight out of reset: eof at offset 0 on line 1
    task automatic test_empty_source();
        gap_max   = 0;
        stall_pct = 0;
        send_byte(lts_pkg::CH_END);
    endtask

    // fraction vs trailing dot, string with a newline inside, comment, keyword,
    // the top byte as an unexpected character, and a string cut off by the end
    task automatic test_corner_cases();
        gap_max   = 2;
        stall_pct = 40;
        append_text("1.5 2.a \"x\ny\"#c\nwhile");
        queue_byte(8'hFF);
        append_text("\"u");
        send_source();
        send_byte(lts_pkg::CH_END);
    endtask

    // random sources, each under its own idle profile; most end the source,
    // some run on into the next one
    task automatic test_random_sources();
        int sent;
        int lexemes;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    gap_max   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_max   = 3;
                    stall_pct = 30;
                end
                2:
                begin
                    gap_max   = 10;
                    stall_pct = 60;
                end
                default:
                begin
                    gap_max   = 1;
                    stall_pct = 85;
                end
            endcase
            lexemes = $urandom_range(1, 24);
            repeat (lexemes) append_lexeme();
            sent += source_bytes.size();
            send_source();
            if ($urandom_range(0, 4) != 0)
            begin
                send_byte(lts_pkg::CH_END);
                sent++;
            end
        end
        send_byte(lts_pkg::CH_END);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_source();
        test_corner_cases();
        test_random_sources();

        // stop sending, let the queue drain, then watch for strays
        in_valid  <= 1'b0;
        stall_pct = 0;
        while (tokens_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_lexical_token_scanner: done, clean");
        else
            $display("tb_lexical_token_scanner: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lts_pkg.sv
rtl/lexical_token_scanner.sv
dv/tb_lexical_token_scanner.sv
